/* hw/rtl/pid_controller_deadband_clamp_unit_defines.svh */
// Assertion macros for the PID controller unit.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef PID_CONTROLLER_DEADBAND_CLAMP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_DEADBAND_CLAMP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PIDC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");

`define PIDC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`else

`define PIDC_ASSERT_ALWAYS(lbl, cond)

`define PIDC_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

/* hw/rtl/pidc_pkg.sv */
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int ERR_W    = 33;
    localparam int DIFF_W   = 34;
    localparam int ACC_W    = 48;
    localparam int DEAD_W   = 31;
    localparam int ACC_LO_W = 16;
    localparam int SUM_W    = 82;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    localparam int INT_LIMIT_UNITS   = 1000;
    localparam int DRIVE_LIMIT_UNITS = 100;

    typedef enum logic [2:0] {
        REG_GAIN_PROP         = 3'd0,
        REG_GAIN_INT_DT       = 3'd1,
        REG_GAIN_DERIV_PER_DT = 3'd2,
        REG_INTEGRAL_FLOOR    = 3'd3,
        REG_INTEGRAL_CEILING  = 3'd4,
        REG_DRIVE_FLOOR       = 3'd5,
        REG_DRIVE_CEILING     = 3'd6,
        REG_DEAD_ZONE         = 3'd7
    } reg_index_t;

    typedef enum logic {
        OP_STEP  = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_prop;
        logic signed [DATA_W-1:0] gain_int_dt;
        logic signed [DATA_W-1:0] gain_deriv_per_dt;
        logic signed [ACC_W-1:0]  integral_floor;
        logic signed [ACC_W-1:0]  integral_ceiling;
        logic signed [DATA_W-1:0] drive_floor;
        logic signed [DATA_W-1:0] drive_ceiling;
        logic        [DEAD_W-1:0] dead_zone;
    } cfg_t;

    // Classified step handed from the front end to the multiply pipeline
    typedef struct packed {
        logic                     clear;
        logic signed [ERR_W-1:0]  err;
        logic signed [ACC_W-1:0]  acc;
        logic signed [DIFF_W-1:0] diff;
    } mid_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [ERR_W-1:0]  err;
        logic signed [ACC_W-1:0]  acc;
    } out_item_t;

endpackage

/* hw/rtl/pidc_fifo.sv */
`timescale 1ns / 1ps

module pidc_fifo #(
    parameter int Width = $bits(pidc_pkg::mid_item_t),
    parameter int Depth = pidc_pkg::MID_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [Width-1:0]             wdata,
    input  logic                         pop,
    output logic [Width-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(Depth+1)-1:0]   level
);

    localparam int AW = $clog2(Depth);
    localparam int LW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;

    // Caller holds credits, so push never lands on a full queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LW'(push) - LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

/* hw/rtl/pidc_front.sv */
`timescale 1ns / 1ps

module pidc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pidc_pkg::cfg_t                    cfg,
    input  logic                              push,
    output logic                              full,
    input  logic                              opcode,
    input  logic signed [pidc_pkg::DATA_W-1:0] measured,
    input  logic signed [pidc_pkg::DATA_W-1:0] target,
    output logic                              mid_push,
    output pidc_pkg::mid_item_t               mid_item,
    input  logic                              mid_pop
);

    import pidc_pkg::*;

    localparam int CntW = $clog2(MID_DEPTH + 1);

    logic [CntW-1:0]          credit_reg, credit_next;
    logic                     accept;

    logic signed [ERR_W-1:0]  raw_err;
    logic        [ERR_W-1:0]  mag;
    logic signed [ERR_W-1:0]  err_next;

    logic                     s1_valid_reg;
    logic                     s1_clear_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ERR_W-1:0]  prev_reg, prev_next;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W:0]    floor_ext;
    logic signed [ACC_W:0]    ceil_ext;
    logic signed [ACC_W-1:0]  acc_clamped;

    logic                     s2_valid_reg;
    mid_item_t                item_reg, item_next;

    // Credits cover both front stages plus the queue behind them
    assign full   = (credit_reg == CntW'(MID_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        credit_next = credit_reg + CntW'(accept) - CntW'(mid_pop);
    end

    // Stage 1: error and deadband
    always_comb
    begin
        raw_err  = {target[DATA_W-1], target} - {measured[DATA_W-1], measured};
        mag      = raw_err[ERR_W-1] ? ERR_W'(-raw_err) : raw_err;
        err_next = (mag < {{(ERR_W - DEAD_W){1'b0}}, cfg.dead_zone}) ? '0 : raw_err;
    end

    // Stage 2: integrator and derivative difference, one step per cycle
    always_comb
    begin
        acc_sum   = {acc_reg[ACC_W-1], acc_reg}
                  + {{(ACC_W + 1 - ERR_W){s1_err_reg[ERR_W-1]}}, s1_err_reg};
        floor_ext = {cfg.integral_floor[ACC_W-1], cfg.integral_floor};
        ceil_ext  = {cfg.integral_ceiling[ACC_W-1], cfg.integral_ceiling};

        // if limits cross, ceiling wins above it and floor at or below
        priority if (acc_sum > ceil_ext)
        begin
            acc_clamped = cfg.integral_ceiling;
        end
        else if (acc_sum < floor_ext)
        begin
            acc_clamped = cfg.integral_floor;
        end
        else
        begin
            acc_clamped = acc_sum[ACC_W-1:0];
        end

        item_next.clear = s1_clear_reg;
        if (s1_clear_reg)
        begin
            item_next.err  = '0;
            item_next.acc  = '0;
            item_next.diff = '0;
            acc_next       = '0;
            prev_next      = '0;
        end
        else
        begin
            item_next.err  = s1_err_reg;
            item_next.acc  = acc_clamped;
            item_next.diff = {s1_err_reg[ERR_W-1], s1_err_reg} - {prev_reg[ERR_W-1], prev_reg};
            acc_next       = acc_clamped;
            prev_next      = s1_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            prev_reg     <= '0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                acc_reg  <= acc_next;
                prev_reg <= prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_clear_reg <= (opcode == OP_CLEAR);
            s1_err_reg   <= err_next;
        end
        if (s1_valid_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign mid_push = s2_valid_reg;
    assign mid_item = item_reg;

endmodule

/* hw/rtl/pidc_back.sv */
`timescale 1ns / 1ps

module pidc_back #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pidc_pkg::cfg_t      cfg,
    input  logic                mid_empty,
    output logic                mid_pop,
    input  pidc_pkg::mid_item_t mid_item,
    output logic                out_push,
    output pidc_pkg::out_item_t out_item,
    input  logic                out_pop
);

    import pidc_pkg::*;

    localparam int CntW   = $clog2(OUT_DEPTH + 1);
    localparam int PROP_W = ERR_W + DATA_W;
    localparam int IHI_W  = (ACC_W - ACC_LO_W) + DATA_W;
    localparam int ILO_W  = ACC_LO_W + 1 + DATA_W;
    localparam int DER_W  = DIFF_W + DATA_W;

    typedef struct packed {
        logic                    clear;
        logic signed [ERR_W-1:0] err;
        logic signed [ACC_W-1:0] acc;
    } tag_t;

    logic [CntW-1:0]          credit_reg, credit_next;

    logic signed [PROP_W-1:0] p_prop;
    logic signed [IHI_W-1:0]  p_ihi;
    logic signed [ILO_W-1:0]  p_ilo;
    logic signed [DER_W-1:0]  p_der;

    logic                     b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;
    tag_t                     b1_tag_reg, b2_tag_reg, b3_tag_reg;
    logic signed [PROP_W-1:0] b1_prop_reg;
    logic signed [IHI_W-1:0]  b1_ihi_reg;
    logic signed [ILO_W-1:0]  b1_ilo_reg;
    logic signed [DER_W-1:0]  b1_der_reg;
    logic signed [SUM_W-1:0]  b2_a_reg, b2_b_reg;
    logic signed [SUM_W-1:0]  b3_sum_reg;
    logic signed [SUM_W-1:0]  floor_ext, ceil_ext;
    logic signed [DATA_W-1:0] drive_next;
    out_item_t                out_reg;

    // Credits cover the four stages plus the result queue
    assign mid_pop = !mid_empty && (credit_reg != CntW'(OUT_DEPTH));

    always_comb
    begin
        credit_next = credit_reg + CntW'(mid_pop) - CntW'(out_pop);
    end

    // Accumulator product split into a signed upper part and an unsigned low part
    assign p_prop = mid_item.err * cfg.gain_prop;
    assign p_ihi  = $signed(mid_item.acc[ACC_W-1:ACC_LO_W]) * cfg.gain_int_dt;
    assign p_ilo  = $signed({1'b0, mid_item.acc[ACC_LO_W-1:0]}) * cfg.gain_int_dt;
    assign p_der  = mid_item.diff * cfg.gain_deriv_per_dt;

    always_comb
    begin
        floor_ext = SUM_W'(cfg.drive_floor);
        ceil_ext  = SUM_W'(cfg.drive_ceiling);
        priority if (b3_tag_reg.clear)
        begin
            drive_next = '0;
        end
        else if (b3_sum_reg > ceil_ext)
        begin
            drive_next = cfg.drive_ceiling;
        end
        else if (b3_sum_reg < floor_ext)
        begin
            drive_next = cfg.drive_floor;
        end
        else
        begin
            drive_next = b3_sum_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            b1_valid_reg <= mid_pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            b1_tag_reg.clear <= mid_item.clear;
            b1_tag_reg.err   <= mid_item.err;
            b1_tag_reg.acc   <= mid_item.acc;
            b1_prop_reg      <= p_prop;
            b1_ihi_reg       <= p_ihi;
            b1_ilo_reg       <= p_ilo;
            b1_der_reg       <= p_der;
        end
        if (b1_valid_reg)
        begin
            b2_tag_reg <= b1_tag_reg;
            b2_a_reg   <= SUM_W'(b1_prop_reg) + SUM_W'(b1_der_reg);
            b2_b_reg   <= (SUM_W'(b1_ihi_reg) <<< ACC_LO_W) + SUM_W'(b1_ilo_reg);
        end
        if (b2_valid_reg)
        begin
            b3_tag_reg <= b2_tag_reg;
            // exact sum with 2F fraction bits, floor toward minus infinity
            b3_sum_reg <= (b2_a_reg + b2_b_reg) >>> FRAC_BITS;
        end
        if (b3_valid_reg)
        begin
            out_reg.drive <= drive_next;
            out_reg.err   <= b3_tag_reg.err;
            out_reg.acc   <= b3_tag_reg.acc;
        end
    end

    assign out_push = b4_valid_reg;
    assign out_item = out_reg;

endmodule

/* hw/rtl/pid_controller_deadband_clamp_unit.sv */
// PID step with deadband, clamped integrator and clamped drive, signed fixed point.
// Throughput: one item per cycle while full stays low; front end keeps the integrator
// loop at one add per cycle, back end runs multiply, two add stages and the output clamp.
// Path: front stages s1 and s2, mid queue, back stages b1 to b4, result queue, then empty low.
// Reset: asynchronous rst_n clears queues, pipeline valids and controller state;
// config registers return to their default limits and zero gains.
`timescale 1ns / 1ps
`include "pid_controller_deadband_clamp_unit_defines.svh"

module pid_controller_deadband_clamp_unit #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pidc_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [pidc_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  opcode,
    input  logic signed [pidc_pkg::DATA_W-1:0]    measured,
    input  logic signed [pidc_pkg::DATA_W-1:0]    target,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [pidc_pkg::DATA_W-1:0]    drive_value,
    output logic signed [pidc_pkg::ERR_W-1:0]     error_value,
    output logic signed [pidc_pkg::ACC_W-1:0]     integral_value
);

    import pidc_pkg::*;

    localparam int MID_LVL_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);
    localparam logic [MID_LVL_W-1:0] MID_LVL_FULL = MID_LVL_W'(MID_DEPTH);
    localparam logic [OUT_LVL_W-1:0] OUT_LVL_FULL = OUT_LVL_W'(OUT_DEPTH);

    localparam logic signed [ACC_W-1:0]  INT_CEIL_RST   = ACC_W'(INT_LIMIT_UNITS) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  INT_FLOOR_RST  = -INT_CEIL_RST;
    localparam logic signed [DATA_W-1:0] DRIVE_CEIL_RST =
        DATA_W'(DRIVE_LIMIT_UNITS) <<< FRAC_BITS;

    cfg_t                 cfg_reg;
    logic                 cfg_wr;
    reg_index_t           cfg_idx;

    logic                 mid_push, mid_pop, mid_empty;
    mid_item_t            mid_wdata, mid_rdata;
    logic [MID_LVL_W-1:0] mid_level;

    logic                 out_push, out_pop;
    out_item_t            out_wdata, out_rdata;
    logic [OUT_LVL_W-1:0] out_level;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop         <= '0;
            cfg_reg.gain_int_dt       <= '0;
            cfg_reg.gain_deriv_per_dt <= '0;
            cfg_reg.integral_floor    <= INT_FLOOR_RST;
            cfg_reg.integral_ceiling  <= INT_CEIL_RST;
            cfg_reg.drive_floor       <= '0;
            cfg_reg.drive_ceiling     <= DRIVE_CEIL_RST;
            cfg_reg.dead_zone         <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GAIN_PROP:         cfg_reg.gain_prop         <= pwdata[DATA_W-1:0];
                REG_GAIN_INT_DT:       cfg_reg.gain_int_dt       <= pwdata[DATA_W-1:0];
                REG_GAIN_DERIV_PER_DT: cfg_reg.gain_deriv_per_dt <= pwdata[DATA_W-1:0];
                REG_INTEGRAL_FLOOR:    cfg_reg.integral_floor    <= pwdata[ACC_W-1:0];
                REG_INTEGRAL_CEILING:  cfg_reg.integral_ceiling  <= pwdata[ACC_W-1:0];
                REG_DRIVE_FLOOR:       cfg_reg.drive_floor       <= pwdata[DATA_W-1:0];
                REG_DRIVE_CEILING:     cfg_reg.drive_ceiling     <= pwdata[DATA_W-1:0];
                REG_DEAD_ZONE:         cfg_reg.dead_zone         <= pwdata[DEAD_W-1:0];
                default:               cfg_reg.dead_zone         <= cfg_reg.dead_zone;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_GAIN_PROP:         prdata = CFG_DATA_W'($unsigned(cfg_reg.gain_prop));
            REG_GAIN_INT_DT:       prdata = CFG_DATA_W'($unsigned(cfg_reg.gain_int_dt));
            REG_GAIN_DERIV_PER_DT: prdata = CFG_DATA_W'($unsigned(cfg_reg.gain_deriv_per_dt));
            REG_INTEGRAL_FLOOR:    prdata = CFG_DATA_W'($unsigned(cfg_reg.integral_floor));
            REG_INTEGRAL_CEILING:  prdata = CFG_DATA_W'($unsigned(cfg_reg.integral_ceiling));
            REG_DRIVE_FLOOR:       prdata = CFG_DATA_W'($unsigned(cfg_reg.drive_floor));
            REG_DRIVE_CEILING:     prdata = CFG_DATA_W'($unsigned(cfg_reg.drive_ceiling));
            REG_DEAD_ZONE:         prdata = CFG_DATA_W'(cfg_reg.dead_zone);
            default:               prdata = '0;
        endcase
    end

    pidc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .opcode   (opcode),
        .measured (measured),
        .target   (target),
        .mid_push (mid_push),
        .mid_item (mid_wdata),
        .mid_pop  (mid_pop)
    );

    pidc_fifo #(
        .Width ($bits(mid_item_t)),
        .Depth (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .level (mid_level)
    );

    pidc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_item  (mid_rdata),
        .out_push  (out_push),
        .out_item  (out_wdata),
        .out_pop   (out_pop)
    );

    assign out_pop = pop && !empty;

    pidc_fifo #(
        .Width ($bits(out_item_t)),
        .Depth (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .pop   (out_pop),
        .rdata (out_rdata),
        .empty (empty),
        .level (out_level)
    );

    assign drive_value    = out_rdata.drive;
    assign error_value    = out_rdata.err;
    assign integral_value = out_rdata.acc;

    `PIDC_ASSERT_IMPLY(a_mid_pop_nonempty, mid_pop, !mid_empty)
    `PIDC_ASSERT_IMPLY(a_mid_no_overflow, mid_push, mid_level != MID_LVL_FULL)
    `PIDC_ASSERT_IMPLY(a_out_no_overflow, out_push, out_level != OUT_LVL_FULL)
    `PIDC_ASSERT_ALWAYS(a_mid_level_range, mid_level <= MID_LVL_FULL)

endmodule
